>>> hdl/mse_pkg.sv
// Package: shared types, opcodes and constants for the MIPS subset execute block.
package mse_pkg;

    localparam int unsigned RegCount = 32;
    localparam logic [31:0] StartAddrReset = 32'h0000_1000;
    localparam logic [31:0] StackTopReset  = 32'h0000_0000;
    localparam int unsigned CfgIdxW = 1;

    localparam logic [CfgIdxW-1:0] CFG_START_ADDRESS = 1'b0;
    localparam logic [CfgIdxW-1:0] CFG_STACK_TOP     = 1'b1;

    localparam logic [31:0] PcRegionMask = 32'hf000_0000;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_ILLEGAL  = 2'd2;
    localparam logic [1:0] ST_SYSCALL  = 2'd3;

    localparam logic [1:0] LD_NONE = 2'd0;
    localparam logic [1:0] LD_LB   = 2'd1;
    localparam logic [1:0] LD_LBU  = 2'd2;
    localparam logic [1:0] LD_LW   = 2'd3;

    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_ORI     = 6'h0d;
    localparam logic [5:0] OP_XORI    = 6'h0e;
    localparam logic [5:0] OP_LUI     = 6'h0f;
    localparam logic [5:0] OP_LB      = 6'h20;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_LBU     = 6'h24;
    localparam logic [5:0] OP_SB      = 6'h28;
    localparam logic [5:0] OP_SW      = 6'h2b;

    localparam logic [5:0] FN_SLL     = 6'h00;
    localparam logic [5:0] FN_SRL     = 6'h02;
    localparam logic [5:0] FN_SRA     = 6'h03;
    localparam logic [5:0] FN_JR      = 6'h08;
    localparam logic [5:0] FN_JALR    = 6'h09;
    localparam logic [5:0] FN_SYSCALL = 6'h0c;
    localparam logic [5:0] FN_ADD     = 6'h20;
    localparam logic [5:0] FN_ADDU    = 6'h21;
    localparam logic [5:0] FN_AND     = 6'h24;
    localparam logic [5:0] FN_OR      = 6'h25;
    localparam logic [5:0] FN_XOR     = 6'h26;
    localparam logic [5:0] FN_SLT     = 6'h2a;

    // operation class decided by the front end
    typedef enum logic [4:0] {
        OPC_ILLEGAL, OPC_LOADDATA, OPC_SLL, OPC_SRL, OPC_SRA, OPC_JR, OPC_JALR,
        OPC_SYSCALL, OPC_ADD, OPC_ADDU, OPC_AND, OPC_OR, OPC_XOR, OPC_SLT,
        OPC_J, OPC_JAL, OPC_BEQ, OPC_BNE, OPC_ADDIU, OPC_ORI, OPC_XORI,
        OPC_LUI, OPC_LB, OPC_LBU, OPC_LW, OPC_SB, OPC_SW
    } t_opc;

    typedef struct packed {
        logic        kind;
        logic [31:0] instr_word;
        logic [31:0] load_data;
    } t_in;

    typedef struct packed {
        t_opc        opc;
        logic [31:0] word;
        logic [31:0] load_data;
    } t_uop;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        mem_request;
        logic        mem_is_write;
        logic        mem_is_word;
        logic [31:0] mem_address;
        logic [31:0] mem_write_data;
        logic [1:0]  status;
        logic [31:0] syscall_number;
        logic [31:0] syscall_argument;
    } t_result;

endpackage

>>> hdl/mse_stream_if.sv
// Interface: valid/ready channel carrying one payload beat.
interface mse_stream_if #(parameter type T = logic) (input logic i_clk);
    logic valid;
    logic ready;
    T     payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> hdl/mse_decode.sv
// Front end: classifies an input beat into an operation class.
module mse_decode import mse_pkg::*; (
    input  logic        i_kind,
    input  logic [31:0] i_word,
    input  logic [31:0] i_load_data,
    output t_uop        o_uop
);
    logic [5:0] op, fn;
    assign op = i_word[31:26];
    assign fn = i_word[5:0];

    always_comb begin
        o_uop.word      = i_word;
        o_uop.load_data = i_load_data;
        o_uop.opc       = OPC_ILLEGAL;
        if (i_kind) begin
            o_uop.opc = OPC_LOADDATA;
        end else begin
            case (op)
                OP_SPECIAL: begin
                    case (fn)
                        FN_SLL:     o_uop.opc = OPC_SLL;
                        FN_SRL:     o_uop.opc = OPC_SRL;
                        FN_SRA:     o_uop.opc = OPC_SRA;
                        FN_JR:      o_uop.opc = OPC_JR;
                        FN_JALR:    o_uop.opc = OPC_JALR;
                        FN_SYSCALL: o_uop.opc = OPC_SYSCALL;
                        FN_ADD:     o_uop.opc = OPC_ADD;
                        FN_ADDU:    o_uop.opc = OPC_ADDU;
                        FN_AND:     o_uop.opc = OPC_AND;
                        FN_OR:      o_uop.opc = OPC_OR;
                        FN_XOR:     o_uop.opc = OPC_XOR;
                        FN_SLT:     o_uop.opc = OPC_SLT;
                        default:    o_uop.opc = OPC_ILLEGAL;
                    endcase
                end
                OP_J:     o_uop.opc = OPC_J;
                OP_JAL:   o_uop.opc = OPC_JAL;
                OP_BEQ:   o_uop.opc = OPC_BEQ;
                OP_BNE:   o_uop.opc = OPC_BNE;
                OP_ADDIU: o_uop.opc = OPC_ADDIU;
                OP_ORI:   o_uop.opc = OPC_ORI;
                OP_XORI:  o_uop.opc = OPC_XORI;
                OP_LUI:   o_uop.opc = OPC_LUI;
                OP_LB:    o_uop.opc = OPC_LB;
                OP_LBU:   o_uop.opc = OPC_LBU;
                OP_LW:    o_uop.opc = OPC_LW;
                OP_SB:    o_uop.opc = OPC_SB;
                OP_SW:    o_uop.opc = OPC_SW;
                default:  o_uop.opc = OPC_ILLEGAL;
            endcase
        end
    end
endmodule

>>> hdl/mse_fifo.sv
// Two-entry queue between the decode front end and the execute back end.
module mse_fifo import mse_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_uop i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_uop o_data
);
    t_uop       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end
endmodule

>>> hdl/mse_execute.sv
// Back end: register file, pc, pending load tracking and result register.
module mse_execute import mse_pkg::*; #(
    parameter int unsigned REG_COUNT = RegCount
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CfgIdxW-1:0]        i_cfg_idx,
    input  logic [31:0]               i_cfg_data,
    input  logic                      i_cfg_hit,
    input  logic                      i_valid,
    input  t_uop                      i_uop,
    output logic                      o_pop,
    output logic                      o_res_valid,
    input  logic                      i_res_ready,
    output t_result                   o_res
);
    localparam int unsigned RW = $clog2(REG_COUNT);
    localparam logic [RW-1:0] RegSp = RW'(29);
    localparam logic [RW-1:0] RegRa = RW'(31);
    localparam logic [RW-1:0] RegV0 = RW'(2);
    localparam logic [RW-1:0] RegA0 = RW'(4);

    logic [31:0]   r_rf [REG_COUNT];
    logic [31:0]   r_pc;
    logic [RW-1:0] r_ld_reg;
    logic [1:0]    r_ld_mode;
    logic          r_res_valid;
    t_result       r_res;

    logic [31:0] w, a, b, seq, simm, sum, wval, n_pc;
    logic [RW-1:0] rs, rt, rd, wreg;
    logic [4:0] sh;
    logic       we;
    logic [1:0] n_ld_mode;
    t_result    res;

    assign o_pop       = i_valid && (!r_res_valid || i_res_ready);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    assign w    = i_uop.word;
    assign rs   = w[21+RW-1:21];
    assign rt   = w[16+RW-1:16];
    assign rd   = w[11+RW-1:11];
    assign sh   = w[10:6];
    assign a    = r_rf[rs];
    assign b    = r_rf[rt];
    assign seq  = r_pc + 32'd4;
    assign simm = {{16{w[15]}}, w[15:0]};
    assign sum  = a + b;

    always_comb begin
        res       = '0;
        n_pc      = seq;
        we        = 1'b0;
        wreg      = rd;
        wval      = '0;
        n_ld_mode = r_ld_mode;
        case (i_uop.opc)
            OPC_LOADDATA: begin
                n_pc      = r_pc;
                n_ld_mode = LD_NONE;
                wreg      = r_ld_reg;
                we        = (r_ld_mode != LD_NONE);
                case (r_ld_mode)
                    LD_LB:   wval = {{24{i_uop.load_data[7]}}, i_uop.load_data[7:0]};
                    LD_LBU:  wval = {24'd0, i_uop.load_data[7:0]};
                    default: wval = i_uop.load_data;
                endcase
            end
            OPC_SLL:  begin we = 1'b1; wval = b << sh; end
            OPC_SRL:  begin we = 1'b1; wval = b >> sh; end
            OPC_SRA:  begin we = 1'b1; wval = $unsigned($signed(b) >>> sh); end
            OPC_JR:   n_pc = a;
            OPC_JALR: begin n_pc = a; we = 1'b1; wval = seq; end
            OPC_SYSCALL: begin
                res.status           = ST_SYSCALL;
                res.syscall_number   = r_rf[RegV0];
                res.syscall_argument = r_rf[RegA0];
            end
            OPC_ADD: begin
                we = 1'b1; wval = sum;
                if (~(a[31] ^ b[31]) & (a[31] ^ sum[31])) begin
                    res.status = ST_OVERFLOW; n_pc = r_pc;
                end
            end
            OPC_ADDU: begin we = 1'b1; wval = sum; end
            OPC_AND:  begin we = 1'b1; wval = a & b; end
            OPC_OR:   begin we = 1'b1; wval = a | b; end
            OPC_XOR:  begin we = 1'b1; wval = a ^ b; end
            OPC_SLT:  begin we = 1'b1; wval = {31'd0, $signed(a) < $signed(b)}; end
            OPC_J:    n_pc = (seq & PcRegionMask) | {4'd0, w[25:0], 2'b00};
            OPC_JAL: begin
                n_pc = (seq & PcRegionMask) | {4'd0, w[25:0], 2'b00};
                we = 1'b1; wreg = RegRa; wval = seq;
            end
            OPC_BEQ: if (a == b) n_pc = seq + {simm[29:0], 2'b00};
            OPC_BNE: if (a != b) n_pc = seq + {simm[29:0], 2'b00};
            OPC_ADDIU: begin we = 1'b1; wreg = rt; wval = a + simm; end
            OPC_ORI:   begin we = 1'b1; wreg = rt; wval = a | {16'd0, w[15:0]}; end
            OPC_XORI:  begin we = 1'b1; wreg = rt; wval = a ^ {16'd0, w[15:0]}; end
            OPC_LUI:   begin we = 1'b1; wreg = rt; wval = {w[15:0], 16'd0}; end
            OPC_LB, OPC_LBU, OPC_LW: begin
                res.mem_request = 1'b1;
                res.mem_address = a + simm;
                res.mem_is_word = (i_uop.opc == OPC_LW);
                n_ld_mode = (i_uop.opc == OPC_LB) ? LD_LB :
                            (i_uop.opc == OPC_LBU) ? LD_LBU : LD_LW;
            end
            OPC_SB, OPC_SW: begin
                res.mem_request    = 1'b1;
                res.mem_is_write   = 1'b1;
                res.mem_address    = a + simm;
                res.mem_is_word    = (i_uop.opc == OPC_SW);
                res.mem_write_data = (i_uop.opc == OPC_SW) ? b : {24'd0, b[7:0]};
            end
            default: begin
                res.status = ST_ILLEGAL; n_pc = r_pc;
            end
        endcase
        res.next_pc = n_pc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= StartAddrReset;
            r_ld_reg    <= '0;
            r_ld_mode   <= LD_NONE;
            r_res_valid <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_hit && i_cfg_idx == CFG_START_ADDRESS) begin
                r_pc <= i_cfg_data;
            end else if (o_pop) begin
                r_pc <= n_pc;
            end
            if (o_pop) begin
                r_ld_mode <= n_ld_mode;
                if (i_uop.opc == OPC_LB || i_uop.opc == OPC_LBU || i_uop.opc == OPC_LW)
                    r_ld_reg <= rt;
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_res <= res;
    end

    // register file: reset clears it except r29; r0 is never written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < REG_COUNT; i++)
                r_rf[i] <= (i == int'(RegSp)) ? StackTopReset : '0;
        end else begin
            if (i_cfg_we && i_cfg_hit && i_cfg_idx == CFG_STACK_TOP) r_rf[RegSp] <= i_cfg_data;
            else if (o_pop && we && wreg != '0) r_rf[wreg] <= wval;
        end
    end
endmodule

>>> hdl/mips_subset_execute.sv
// Top level: MIPS32 integer subset execute block.
// One instruction or load-data beat is accepted per cycle while the two-entry decode
// queue is not full; its result appears in the cycle after it leaves the queue, so a
// stream runs at one item per cycle while the output is not stalled. The register-file
// read, ALU and writeback of one item complete together in the back end.
// Loads and stores leave as memory requests; the host answers a load with a beat of
// kind 1. Configuration writes load the pc (index 0) or r29 (index 1) immediately.
module mips_subset_execute import mse_pkg::*; #(
    parameter int unsigned REG_COUNT = RegCount
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    mse_stream_if.sink   s_in,
    mse_stream_if.source m_out
);
    t_uop    dec_uop, q_uop;
    logic    q_full, q_valid, pop;
    t_result res;
    logic    cfg_hit;

    assign cfg_hit = (i_cfg_idx[31:CfgIdxW] == '0);

    mse_decode u_dec (
        .i_kind      (s_in.payload.kind),
        .i_word      (s_in.payload.instr_word),
        .i_load_data (s_in.payload.load_data),
        .o_uop       (dec_uop)
    );

    assign s_in.ready = !q_full;

    mse_fifo u_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_in.valid && !q_full),
        .i_data  (dec_uop),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_uop)
    );

    mse_execute #(.REG_COUNT(REG_COUNT)) u_exe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx[CfgIdxW-1:0]),
        .i_cfg_data  (i_cfg_data),
        .i_cfg_hit   (cfg_hit),
        .i_valid     (q_valid),
        .i_uop       (q_uop),
        .o_pop       (pop),
        .o_res_valid (m_out.valid),
        .i_res_ready (m_out.ready),
        .o_res       (res)
    );

    assign m_out.payload = res;

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_valid) else $error("pop from empty queue");
    a_pop_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> m_out.valid) else $error("result missing after pop");
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_out.valid && !m_out.ready) |=> !$past(pop)) else $error("result overwritten");
endmodule
